[hw/rtl/plst_pkg.sv]
// ============================================================================
// plst_pkg - positional list store shared definitions
// field widths, action codes, sequencer states and default sizes
// ============================================================================
package plst_pkg;

    // payload field widths on the channels
    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int ENTRY_W  = 32;
    localparam int COUNT_W  = 7;

    // default sizing
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_READ   = 3'd2,
        ACT_WRITE  = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SH_RD,
        ST_SH_WR,
        ST_WRITE,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

[hw/rtl/plst_in_if.sv]
// ============================================================================
// plst_in_if - request channel of the positional list store
// valid/ready handshake carrying action, position and entry
// ============================================================================
interface plst_in_if
    import plst_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    position;
    logic [ENTRY_W-1:0]  entry_in;

    modport source (output valid, action, position, entry_in, input ready);
    modport sink   (input valid, action, position, entry_in, output ready);
endinterface

[hw/rtl/plst_out_if.sv]
// ============================================================================
// plst_out_if - result channel of the positional list store
// valid/ready handshake carrying status, read entry and count
// ============================================================================
interface plst_out_if
    import plst_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               ok;
    logic [ENTRY_W-1:0] entry_out;
    logic [COUNT_W-1:0] count;
    logic               empty_res;

    modport source (output valid, ok, entry_out, count, empty_res, input ready);
    modport sink   (input valid, ok, entry_out, count, empty_res, output ready);
endinterface

[hw/rtl/positional_list_store_unit.sv]
// ============================================================================
// positional_list_store_unit - ordered list with insert/remove by position
// one memory, one read and one write port, driven by a small sequencer
// ============================================================================
// usage
//   i_in carries one request item: action (insert, remove, read, write,
//   clear), a 1-based position and an entry. o_out returns one result item
//   per request: ok flag, the entry read (zero unless an accepted read),
//   the count after the action and an empty flag. a request is taken only
//   while the sequencer is idle; i_in.ready is low for an item's whole work
// sequence
//   clear, rejected items: done state, then the result is registered.
//   read: read, done. write: write, done. insert: a shift read and write
//   per moved entry, then write, done. remove: the same moves, then done.
//   entries moved: count - position + 1 for insert, count - position for
//   remove; each move is one memory read and one write through the single
//   port pair. the next request is taken the cycle after the result is loaded
// reset
//   synchronous, active low; state, count and output valid clear, i_in.ready
//   is low meanwhile. the entry memory is not cleared
// stalls
//   a result waits in the output register while o_out.ready is low; the
//   next item may be taken meanwhile and its result waits in the done state
// ============================================================================
module positional_list_store_unit
    import plst_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plst_in_if.sink     i_in,
    plst_out_if.source  o_out
);

    // storage width: upper entry bits beyond the port are always zero
    localparam int SW = (DATA_WIDTH < ENTRY_W) ? DATA_WIDTH : ENTRY_W;
    // address and count widths follow the capacity
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    // compare width wide enough for both position and count plus one
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    // entry memory, no reset
    logic [SW-1:0] mem [CAPACITY];

    // control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx,   n_idx;
    logic            r_ok,    n_ok;

    // latched request
    logic [ACTION_W-1:0] r_act;
    logic [AW-1:0]       r_addr;
    logic [SW-1:0]       r_val;

    // memory read data
    logic [SW-1:0] r_rdata;

    // output register
    logic               r_out_valid;
    logic               r_out_ok;
    logic [ENTRY_W-1:0] r_out_entry;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_empty;

    // sequencer outputs
    logic          in_ready;
    logic          accept;
    logic          out_load;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [SW-1:0] mem_wdata;

    // request decode
    logic [XW-1:0] pos_x;
    logic [XW-1:0] cnt_x;
    logic          pos_nz;
    logic          in_list;
    logic          ins_ok;
    logic [AW-1:0] addr_in;

    assign accept  = i_in.valid && in_ready;
    assign pos_x   = XW'(i_in.position);
    assign cnt_x   = XW'(r_count);
    assign pos_nz  = (pos_x != '0);
    assign in_list = pos_nz && (pos_x <= cnt_x);
    // insert before 1..count+1, and only while there is room
    assign ins_ok  = pos_nz && (pos_x <= cnt_x + XW'(1)) && (cnt_x < XW'(CAPACITY));
    // zero-based slot; only used when the position is valid
    assign addr_in = AW'(pos_x - XW'(1));

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_ok    = r_ok;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_in.action)
                        ACT_INSERT: begin
                            n_ok = ins_ok;
                            if (!ins_ok) begin
                                n_state = ST_DONE;
                            end else if (in_list) begin
                                // entries from position onwards move up, top first
                                n_idx   = AW'(r_count);
                                n_state = ST_SH_RD;
                            end else begin
                                // append at the end, nothing to move
                                n_state = ST_WRITE;
                            end
                        end
                        ACT_REMOVE: begin
                            n_ok = in_list;
                            if (in_list && (pos_x < cnt_x)) begin
                                // entries above the gap move down, bottom first
                                n_idx   = addr_in;
                                n_state = ST_SH_RD;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        ACT_READ: begin
                            n_ok    = in_list;
                            n_state = in_list ? ST_READ : ST_DONE;
                        end
                        ACT_WRITE: begin
                            n_ok    = in_list;
                            n_state = in_list ? ST_WRITE : ST_DONE;
                        end
                        ACT_CLEAR: begin
                            n_ok    = 1'b1;
                            n_state = ST_DONE;
                        end
                        default: begin
                            // unused action codes are rejected
                            n_ok    = 1'b0;
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SH_RD: begin
                n_state = ST_SH_WR;
            end
            ST_SH_WR: begin
                if (r_act == ACT_INSERT) begin
                    n_idx = AW'(r_idx - 1'b1);
                    // last move fills the slot just above the insert point
                    n_state = (AW'(r_idx - 1'b1) == r_addr) ? ST_WRITE : ST_SH_RD;
                end else begin
                    n_idx = AW'(r_idx + 1'b1);
                    n_state = ((CW + 1)'(r_idx) + (CW + 1)'(2) >= (CW + 1)'(r_count))
                              ? ST_DONE : ST_SH_RD;
                end
            end
            ST_WRITE: begin
                n_state = ST_DONE;
            end
            ST_READ: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // count update on the way out of the done state, once per item
        if (r_state == ST_DONE && out_load && r_ok) begin
            case (r_act)
                ACT_INSERT: n_count = CW'(r_count + 1'b1);
                ACT_REMOVE: n_count = CW'(r_count - 1'b1);
                ACT_CLEAR:  n_count = '0;
                default:    n_count = r_count;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // sequencer outputs
    // ------------------------------------------------------------------------
    always_comb begin
        in_ready  = 1'b0;
        out_load  = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_addr;
        mem_raddr = r_addr;
        mem_wdata = r_val;
        unique case (r_state)
            ST_IDLE: begin
                // nothing is taken while reset is held
                in_ready = i_rst_n;
            end
            ST_SH_RD: begin
                mem_re    = 1'b1;
                mem_raddr = (r_act == ACT_INSERT) ? AW'(r_idx - 1'b1)
                                                  : AW'(r_idx + 1'b1);
            end
            ST_SH_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                mem_wdata = r_rdata;
            end
            ST_WRITE: begin
                mem_we = 1'b1;
            end
            ST_READ: begin
                mem_re = 1'b1;
            end
            ST_DONE: begin
                out_load = !r_out_valid || o_out.ready;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // entry memory
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ok    <= n_ok;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (accept) begin
            r_act  <= i_in.action;
            r_addr <= addr_in;
            r_val  <= i_in.entry_in[SW-1:0];
        end
        if (out_load) begin
            r_out_ok    <= r_ok;
            r_out_entry <= (r_ok && r_act == ACT_READ) ? ENTRY_W'(r_rdata) : '0;
            r_out_count <= COUNT_W'(n_count);
            r_out_empty <= (n_count == '0);
        end
    end

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.ok        = r_out_ok;
    assign o_out.entry_out = r_out_entry;
    assign o_out.count     = r_out_count;
    assign o_out.empty_res = r_out_empty;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW + 1)'(r_count) <= (CW + 1)'(CAPACITY))
        else $error("entry count above capacity");

    a_write_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (CW'(mem_waddr) <= r_count))
        else $error("memory write beyond the end of the list");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE) && !i_in.ready)
        else $error("request taken while an item is still in work");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_ok && r_act == ACT_CLEAR) |=> (r_count == '0) && r_out_empty)
        else $error("clear left entries in the list");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid && $stable(r_out_count))
        else $error("pending result lost while stalled");

endmodule

[tb/sv/plst_list_check_pkg.sv]
`timescale 1ns / 100ps
// ============================================================================
// plst_list_check_pkg - shadow list and result scoreboard
// keeps its own copy of the ordered list, works out the result item of each
// accepted request and compares the block's results against them in order
// ============================================================================
package plst_list_check_pkg;
    import plst_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [ENTRY_W-1:0] entry;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } t_list_result;

    class list_tracker;
        logic [ENTRY_W-1:0] slot [CAPACITY_DEF];
        int unsigned        fill;
        int unsigned        mismatches;
        t_list_result       awaited_q [$];

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return awaited_q.size();
        endfunction

        // apply one accepted request to the shadow list, queue its result
        function void note_request(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                                   logic [ENTRY_W-1:0] val);
            t_list_result exp_res;
            int unsigned  p;
            int unsigned  i;
            p       = pos;
            exp_res = '0;
            case (act)
                ACT_INSERT: begin
                    if (p >= 1 && p <= fill + 1 && fill < CAPACITY_DEF) begin
                        for (i = fill; i >= p; i--)
                            slot[i] = slot[i-1];
                        slot[p-1] = val;
                        fill++;
                        exp_res.ok = 1'b1;
                    end
                end
                ACT_REMOVE: begin
                    if (p >= 1 && p <= fill) begin
                        for (i = p - 1; i + 1 < fill; i++)
                            slot[i] = slot[i+1];
                        fill--;
                        exp_res.ok = 1'b1;
                    end
                end
                ACT_READ: begin
                    if (p >= 1 && p <= fill) begin
                        exp_res.entry = slot[p-1];
                        exp_res.ok    = 1'b1;
                    end
                end
                ACT_WRITE: begin
                    if (p >= 1 && p <= fill) begin
                        slot[p-1]  = val;
                        exp_res.ok = 1'b1;
                    end
                end
                ACT_CLEAR: begin
                    fill       = 0;
                    exp_res.ok = 1'b1;
                end
                default: ;
            endcase
            exp_res.count = COUNT_W'(fill);
            exp_res.empty = (fill == 0);
            awaited_q.push_back(exp_res);
        endfunction

        function void check_result(logic ok, logic [ENTRY_W-1:0] entry,
                                   logic [COUNT_W-1:0] count, logic empty);
            t_list_result exp_res;
            if (awaited_q.size() == 0) begin
                $error("result item with nothing expected");
                mismatches++;
                return;
            end
            exp_res = awaited_q.pop_front();
            if (ok !== exp_res.ok) begin
                $error("ok: expected %0d, got %0d", exp_res.ok, ok);
                mismatches++;
            end
            if (entry !== exp_res.entry) begin
                $error("entry_out: expected %08h, got %08h", exp_res.entry, entry);
                mismatches++;
            end
            if (count !== exp_res.count) begin
                $error("count: expected %0d, got %0d", exp_res.count, count);
                mismatches++;
            end
            if (empty !== exp_res.empty) begin
                $error("empty_res: expected %0d, got %0d", exp_res.empty, empty);
                mismatches++;
            end
        endfunction
    endclass

endpackage

[tb/sv/tb_positional_list_store_unit.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_positional_list_store_unit - positional list store testbench
// drives insert, remove, read, write and clear requests with random gaps on
// both channels, predicts every result item on a shadow list and checks the
// results in order; a long output hold-off makes the block stall its input
// ============================================================================
module tb_positional_list_store_unit;
    import plst_pkg::*;
    import plst_list_check_pkg::*;

    // action codes the block does not define, still legal on the field
    localparam logic [ACTION_W-1:0] ACT_SPARE_5 = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1650;
    localparam int PHASE_LEN    = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT_ITEM = 500;
    // worst insert moves 63 entries, plus the long hold-off
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 20;

    logic        i_clk;
    logic        i_rst_n;
    logic        quiet;         // no idling on either side
    logic        hold;          // result side holds off
    int unsigned items_sent;
    int unsigned idle_cycles;
    list_tracker tracker;

    plst_in_if  req_if ();
    plst_out_if res_if ();

    positional_list_store_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // offer one request item, with a random gap first, and wait for it to be
    // taken; the shadow list is updated right at acceptance so the next pick
    // sees the count the block will have
    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [POS_W-1:0]    pos,
                                input logic [ENTRY_W-1:0]  val);
        if (!quiet) begin
            while ($urandom_range(99) < 34) begin
                req_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        req_if.valid    <= 1'b1;
        req_if.action   <= act;
        req_if.position <= pos;
        req_if.entry_in <= val;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        tracker.note_request(act, pos, val);
        items_sent++;
    endtask

    // result side: check each accepted result item, then pick the next ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready)
                tracker.check_result(res_if.ok, res_if.entry_out, res_if.count,
                                     res_if.empty_res);
            res_if.ready <= !hold && (quiet || $urandom_range(99) >= 34);
        end
    end

    // long hold-off while requests keep coming, so the block backs up
    initial begin
        hold <= 1'b0;
        wait (items_sent >= HOLD_AT_ITEM);
        @(posedge i_clk);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold <= 1'b0;
    end

    // watchdog: cycles in a row with no item moving on either channel
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_positional_list_store_unit: errors");
                $finish;
            end
        end
    end

    initial begin
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0]    pos;
        logic [ENTRY_W-1:0]  val;
        int unsigned         cnt;
        int unsigned         roll;
        int unsigned         ins_lim, rem_lim, rd_lim, wr_lim;

        tracker         = new();
        items_sent      = 0;
        idle_cycles     = 0;
        quiet           <= 1'b0;
        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.action   <= ACT_INSERT;
        req_if.position <= '0;
        req_if.entry_in <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty list, edges of insert range, end positions,
        // rejected positions, spare codes and clear
        send_request(ACT_CLEAR,   7'd1,   32'h0000_0000);
        send_request(ACT_REMOVE,  7'd1,   32'h0000_0000);
        send_request(ACT_READ,    7'd1,   32'h0000_0000);
        send_request(ACT_WRITE,   7'd1,   32'hFFFF_FFFF);
        send_request(ACT_INSERT,  7'd0,   32'h1111_1111);
        send_request(ACT_INSERT,  7'd2,   32'h2222_2222);
        send_request(ACT_INSERT,  7'd1,   32'h0000_0000);
        send_request(ACT_INSERT,  7'd2,   32'hFFFF_FFFF);
        send_request(ACT_INSERT,  7'd1,   32'hA5A5_A5A5);
        send_request(ACT_INSERT,  7'd4,   32'h5A5A_5A5A);
        send_request(ACT_READ,    7'd1,   32'h0000_0000);
        send_request(ACT_READ,    7'd4,   32'h0000_0000);
        send_request(ACT_READ,    7'd5,   32'h0000_0000);
        send_request(ACT_READ,    7'd127, 32'hFFFF_FFFF);
        send_request(ACT_WRITE,   7'd2,   32'h1234_5678);
        send_request(ACT_READ,    7'd2,   32'h0000_0000);
        send_request(ACT_REMOVE,  7'd2,   32'h0000_0000);
        send_request(ACT_REMOVE,  7'd3,   32'h0000_0000);
        send_request(ACT_REMOVE,  7'd3,   32'h0000_0000);
        send_request(ACT_SPARE_5, 7'd1,   32'hFFFF_FFFF);
        send_request(ACT_SPARE_6, 7'd1,   32'h0000_0000);
        send_request(ACT_SPARE_7, 7'd64,  32'hFFFF_FFFF);
        send_request(ACT_CLEAR,   7'd127, 32'hFFFF_FFFF);
        send_request(ACT_READ,    7'd1,   32'h0000_0000);

        // random: phases that grow the list to full, shrink it, and mix;
        // mostly in-range positions, with a share of raw noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet <= (n >= 900 && n < 1100);
            case ((n / PHASE_LEN) % 3)
                0: begin ins_lim = 65; rem_lim = 75; rd_lim = 88; wr_lim = 98; end
                1: begin ins_lim = 15; rem_lim = 70; rd_lim = 85; wr_lim = 99; end
                default: begin ins_lim = 40; rem_lim = 70; rd_lim = 85; wr_lim = 98; end
            endcase
            cnt  = tracker.fill;
            val  = $urandom;
            roll = $urandom_range(9);
            if (roll == 0)
                val = '0;
            else if (roll == 1)
                val = '1;
            if ($urandom_range(99) < 12) begin
                act = ACTION_W'($urandom_range(7));
                pos = POS_W'($urandom_range(127));
            end else begin
                roll = $urandom_range(99);
                if (roll < ins_lim)
                    act = ACT_INSERT;
                else if (roll < rem_lim)
                    act = ACT_REMOVE;
                else if (roll < rd_lim)
                    act = ACT_READ;
                else if (roll < wr_lim)
                    act = ACT_WRITE;
                else
                    act = ACT_CLEAR;
                // nothing to address in an empty list, so grow it instead
                if (cnt == 0 && act != ACT_CLEAR)
                    act = ACT_INSERT;
                if (act == ACT_INSERT)
                    pos = POS_W'($urandom_range(cnt + 1, 1));
                else if (act == ACT_CLEAR)
                    pos = POS_W'($urandom_range(127));
                else
                    pos = POS_W'($urandom_range(cnt, 1));
            end
            send_request(act, pos, val);
        end
        req_if.valid <= 1'b0;
        quiet        <= 1'b0;

        // drain: every expected result back, then a short settle
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("tb_positional_list_store_unit: clean");
        else
            $display("tb_positional_list_store_unit: errors");
        $finish;
    end

endmodule
